[rtl/core/bshe_pkg.sv]
// bshe_pkg: shared types, codes and constants of the byte stream hash engine
// no dependencies; used by bshe_mul, bshe_seq and byte_stream_hash_engine
`timescale 1ns / 1ps
`default_nettype none

package bshe_pkg;

    // hash mode codes
    localparam logic [1:0] MODE_FNV32 = 2'd0;
    localparam logic [1:0] MODE_FNV64 = 2'd1;
    localparam logic [1:0] MODE_MUR32 = 2'd2;
    localparam logic [1:0] MODE_MUR64 = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_HASH_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HASH_SEED = 1'b1;

    // algorithm constants
    localparam logic [63:0] FNV32_BASIS = 64'd2166136261;
    localparam logic [63:0] FNV32_MUL   = 64'h0000_0000_0100_0193;
    localparam logic [63:0] FNV64_BASIS = 64'd14695981039346656037;
    localparam logic [63:0] FNV64_MUL   = 64'h0000_0100_0000_01B3;
    localparam logic [63:0] MUR32_M     = 64'h0000_0000_5BD1_E995;
    localparam logic [63:0] MUR64_M     = 64'hC6A4_A793_5BD1_E995;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_BYTE,
        S_MUL_GO,
        S_MUL_WAIT,
        S_FIN,
        S_EMIT
    } seq_state_t;

    // multiply operations issued to the shared multiplier
    typedef enum logic [3:0] {
        MOP_INIT64,
        MOP_FNV32,
        MOP_FNV64,
        MOP_K1_32,
        MOP_K2_32,
        MOP_H_32,
        MOP_K1_64,
        MOP_K2_64,
        MOP_H_64,
        MOP_TAIL_32,
        MOP_F2_32,
        MOP_TAIL_64,
        MOP_F2_64
    } mop_t;

    // multiplier request and response
    typedef struct packed {
        logic        start;
        logic        wide;
        logic [63:0] opa;
        logic [63:0] opb;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] product;
    } mul_rsp_t;

endpackage

`default_nettype wire

[rtl/core/bshe_mul.sv]
// bshe_mul: shared multiplier giving the low 64 bits of a 64x64 product (wide) or the 32x32 product of the low halves
// one 32x32 partial product per cycle; depends on bshe_pkg
`timescale 1ns / 1ps
`default_nettype none

module bshe_mul (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  bshe_pkg::mul_req_t      req,
    output bshe_pkg::mul_rsp_t      rsp
);

    localparam logic [1:0] MSTEP_LL = 2'd0;
    localparam logic [1:0] MSTEP_HL = 2'd1;
    localparam logic [1:0] MSTEP_LH = 2'd2;

    logic [63:0] opa_reg;
    logic [63:0] opb_reg;
    logic        wide_reg;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic        busy_reg;
    logic        busy_next;
    logic [1:0]  step_reg;
    logic [1:0]  step_next;
    logic        done_reg;
    logic        done_next;
    logic [31:0] mx;
    logic [31:0] my;
    logic [63:0] prod;
    logic        last_step;

    // partial product operand select
    always_comb
    begin
        case (step_reg)
            MSTEP_LL:
            begin
                mx = opa_reg[31:0];
                my = opb_reg[31:0];
            end
            MSTEP_HL:
            begin
                mx = opa_reg[63:32];
                my = opb_reg[31:0];
            end
            MSTEP_LH:
            begin
                mx = opa_reg[31:0];
                my = opb_reg[63:32];
            end
            default:
            begin
                mx = 32'd0;
                my = 32'd0;
            end
        endcase
    end

    // one 32x32 multiply, accumulated into the low 64 bits
    assign prod      = {32'd0, mx} * {32'd0, my};
    assign acc_next  = (step_reg == MSTEP_LL) ? prod : acc_reg + {prod[31:0], 32'd0};
    assign last_step = !wide_reg || (step_reg == MSTEP_LH);

    // step control
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = MSTEP_LL;
        end
        else if (busy_reg)
        begin
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= MSTEP_LL;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    // operands and accumulator
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            opa_reg  <= req.opa;
            opb_reg  <= req.opb;
            wide_reg <= req.wide;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

`default_nettype wire

[rtl/core/bshe_seq.sv]
// bshe_seq: per-byte sequencer and hash state of the byte stream hash engine
// drives the shared bshe_mul; depends on bshe_pkg
`timescale 1ns / 1ps
`default_nettype none

module bshe_seq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_fire,
    input  wire logic [7:0]         data_byte,
    input  wire logic               byte_present,
    input  wire logic               last_byte,
    input  wire logic [31:0]        message_length,
    input  wire logic [1:0]         hash_mode,
    input  wire logic [63:0]        hash_seed,
    input  wire logic               slot_free,
    output logic                    item_stall,
    output logic                    emit,
    output logic [63:0]             emit_value,
    output bshe_pkg::mul_req_t      mul_req,
    input  bshe_pkg::mul_rsp_t      mul_rsp
);

    bshe_pkg::seq_state_t state_reg, state_next;
    bshe_pkg::mop_t       mop_reg, mop_next;

    logic [63:0] h_reg, h_next;
    logic [63:0] k_reg, k_next;
    logic [63:0] blk_reg, blk_next;
    logic [2:0]  fill_reg, fill_next;
    logic        in_msg_reg, in_msg_next;
    logic [63:0] res_reg, res_next;

    logic [7:0]  byte_reg;
    logic        present_reg;
    logic        last_reg;
    logic [31:0] len_reg;

    logic [3:0]  pos4;
    logic [63:0] blk_ins;
    logic [63:0] p;
    logic [31:0] p32;
    logic [31:0] h32;

    // byte insertion into the pending little-endian block
    assign pos4    = {1'b0, fill_reg} + 4'd1;
    assign blk_ins = blk_reg | ({56'd0, byte_reg} << {fill_reg, 3'b000});
    assign p       = mul_rsp.product;
    assign p32     = mul_rsp.product[31:0];
    assign h32     = h_reg[31:0];

    // multiplier operands per operation
    always_comb
    begin
        mul_req.start = (state_reg == bshe_pkg::S_MUL_GO);
        case (mop_reg)
            bshe_pkg::MOP_INIT64:
            begin
                mul_req.wide = 1'b1;
                mul_req.opa  = {32'd0, len_reg};
                mul_req.opb  = bshe_pkg::MUR64_M;
            end
            bshe_pkg::MOP_FNV32:
            begin
                mul_req.wide = 1'b0;
                mul_req.opa  = {32'd0, h32 ^ {24'd0, byte_reg}};
                mul_req.opb  = bshe_pkg::FNV32_MUL;
            end
            bshe_pkg::MOP_FNV64:
            begin
                mul_req.wide = 1'b1;
                mul_req.opa  = h_reg ^ {56'd0, byte_reg};
                mul_req.opb  = bshe_pkg::FNV64_MUL;
            end
            bshe_pkg::MOP_K1_32, bshe_pkg::MOP_K2_32:
            begin
                mul_req.wide = 1'b0;
                mul_req.opa  = k_reg;
                mul_req.opb  = bshe_pkg::MUR32_M;
            end
            bshe_pkg::MOP_H_32, bshe_pkg::MOP_F2_32:
            begin
                mul_req.wide = 1'b0;
                mul_req.opa  = h_reg;
                mul_req.opb  = bshe_pkg::MUR32_M;
            end
            bshe_pkg::MOP_TAIL_32:
            begin
                mul_req.wide = 1'b0;
                mul_req.opa  = h_reg ^ blk_reg;
                mul_req.opb  = bshe_pkg::MUR32_M;
            end
            bshe_pkg::MOP_K1_64, bshe_pkg::MOP_K2_64:
            begin
                mul_req.wide = 1'b1;
                mul_req.opa  = k_reg;
                mul_req.opb  = bshe_pkg::MUR64_M;
            end
            bshe_pkg::MOP_H_64, bshe_pkg::MOP_F2_64:
            begin
                mul_req.wide = 1'b1;
                mul_req.opa  = h_reg;
                mul_req.opb  = bshe_pkg::MUR64_M;
            end
            bshe_pkg::MOP_TAIL_64:
            begin
                mul_req.wide = 1'b1;
                mul_req.opa  = h_reg ^ blk_reg;
                mul_req.opb  = bshe_pkg::MUR64_M;
            end
            default:
            begin
                mul_req.wide = 1'b0;
                mul_req.opa  = 64'd0;
                mul_req.opb  = 64'd0;
            end
        endcase
    end

    // next state and hash state updates
    always_comb
    begin
        state_next  = state_reg;
        mop_next    = mop_reg;
        h_next      = h_reg;
        k_next      = k_reg;
        blk_next    = blk_reg;
        fill_next   = fill_reg;
        in_msg_next = in_msg_reg;
        res_next    = res_reg;
        emit        = 1'b0;
        item_stall  = (state_reg != bshe_pkg::S_IDLE);

        case (state_reg)
            bshe_pkg::S_IDLE:
            begin
                if (item_fire)
                begin
                    state_next = bshe_pkg::S_INIT;
                end
            end

            // open a message on its first item
            bshe_pkg::S_INIT:
            begin
                state_next = bshe_pkg::S_BYTE;
                if (!in_msg_reg)
                begin
                    blk_next    = 64'd0;
                    fill_next   = 3'd0;
                    in_msg_next = 1'b1;
                    case (hash_mode)
                        bshe_pkg::MODE_FNV32: h_next = bshe_pkg::FNV32_BASIS;
                        bshe_pkg::MODE_FNV64: h_next = bshe_pkg::FNV64_BASIS;
                        bshe_pkg::MODE_MUR32: h_next = {32'd0, hash_seed[31:0] ^ len_reg};
                        bshe_pkg::MODE_MUR64:
                        begin
                            mop_next   = bshe_pkg::MOP_INIT64;
                            state_next = bshe_pkg::S_MUL_GO;
                        end
                        default: h_next = h_reg;
                    endcase
                end
            end

            // absorb the byte
            bshe_pkg::S_BYTE:
            begin
                state_next = bshe_pkg::S_FIN;
                if (present_reg)
                begin
                    case (hash_mode)
                        bshe_pkg::MODE_FNV32:
                        begin
                            mop_next   = bshe_pkg::MOP_FNV32;
                            state_next = bshe_pkg::S_MUL_GO;
                        end
                        bshe_pkg::MODE_FNV64:
                        begin
                            mop_next   = bshe_pkg::MOP_FNV64;
                            state_next = bshe_pkg::S_MUL_GO;
                        end
                        bshe_pkg::MODE_MUR32:
                        begin
                            if (pos4 >= 4'd4)
                            begin
                                k_next     = {32'd0, blk_ins[31:0]};
                                blk_next   = 64'd0;
                                fill_next  = 3'd0;
                                mop_next   = bshe_pkg::MOP_K1_32;
                                state_next = bshe_pkg::S_MUL_GO;
                            end
                            else
                            begin
                                blk_next  = blk_ins;
                                fill_next = pos4[2:0];
                            end
                        end
                        bshe_pkg::MODE_MUR64:
                        begin
                            if (pos4 == 4'd8)
                            begin
                                k_next     = blk_ins;
                                blk_next   = 64'd0;
                                fill_next  = 3'd0;
                                mop_next   = bshe_pkg::MOP_K1_64;
                                state_next = bshe_pkg::S_MUL_GO;
                            end
                            else
                            begin
                                blk_next  = blk_ins;
                                fill_next = pos4[2:0];
                            end
                        end
                        default: state_next = bshe_pkg::S_FIN;
                    endcase
                end
            end

            bshe_pkg::S_MUL_GO:
            begin
                state_next = bshe_pkg::S_MUL_WAIT;
            end

            // write back the product and chain the next operation
            bshe_pkg::S_MUL_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    state_next = bshe_pkg::S_MUL_GO;
                    case (mop_reg)
                        bshe_pkg::MOP_INIT64:
                        begin
                            h_next     = hash_seed ^ p;
                            state_next = bshe_pkg::S_BYTE;
                        end
                        bshe_pkg::MOP_FNV32:
                        begin
                            h_next     = {32'd0, p32};
                            state_next = bshe_pkg::S_FIN;
                        end
                        bshe_pkg::MOP_FNV64:
                        begin
                            h_next     = p;
                            state_next = bshe_pkg::S_FIN;
                        end
                        bshe_pkg::MOP_K1_32:
                        begin
                            k_next   = {32'd0, p32 ^ (p32 >> 24)};
                            mop_next = bshe_pkg::MOP_K2_32;
                        end
                        bshe_pkg::MOP_K2_32:
                        begin
                            k_next   = {32'd0, p32};
                            mop_next = bshe_pkg::MOP_H_32;
                        end
                        bshe_pkg::MOP_H_32:
                        begin
                            h_next     = {32'd0, p32 ^ k_reg[31:0]};
                            state_next = bshe_pkg::S_FIN;
                        end
                        bshe_pkg::MOP_K1_64:
                        begin
                            k_next   = p ^ (p >> 47);
                            mop_next = bshe_pkg::MOP_K2_64;
                        end
                        bshe_pkg::MOP_K2_64:
                        begin
                            h_next   = h_reg ^ p;
                            mop_next = bshe_pkg::MOP_H_64;
                        end
                        bshe_pkg::MOP_H_64:
                        begin
                            h_next     = p;
                            state_next = bshe_pkg::S_FIN;
                        end
                        bshe_pkg::MOP_TAIL_32:
                        begin
                            h_next   = {32'd0, p32 ^ (p32 >> 13)};
                            mop_next = bshe_pkg::MOP_F2_32;
                        end
                        bshe_pkg::MOP_F2_32:
                        begin
                            res_next   = {32'd0, p32 ^ (p32 >> 15)};
                            state_next = bshe_pkg::S_EMIT;
                        end
                        bshe_pkg::MOP_TAIL_64:
                        begin
                            h_next   = p ^ (p >> 47);
                            mop_next = bshe_pkg::MOP_F2_64;
                        end
                        bshe_pkg::MOP_F2_64:
                        begin
                            res_next   = p ^ (p >> 47);
                            state_next = bshe_pkg::S_EMIT;
                        end
                        default: state_next = bshe_pkg::S_IDLE;
                    endcase
                end
            end

            // finalize on the last item
            bshe_pkg::S_FIN:
            begin
                if (!last_reg)
                begin
                    state_next = bshe_pkg::S_IDLE;
                end
                else
                begin
                    state_next = bshe_pkg::S_MUL_GO;
                    case (hash_mode)
                        bshe_pkg::MODE_FNV32:
                        begin
                            res_next   = {32'd0, h32};
                            state_next = bshe_pkg::S_EMIT;
                        end
                        bshe_pkg::MODE_FNV64:
                        begin
                            res_next   = h_reg;
                            state_next = bshe_pkg::S_EMIT;
                        end
                        bshe_pkg::MODE_MUR32:
                        begin
                            if (fill_reg != 3'd0)
                            begin
                                mop_next = bshe_pkg::MOP_TAIL_32;
                            end
                            else
                            begin
                                h_next   = {32'd0, h32 ^ (h32 >> 13)};
                                mop_next = bshe_pkg::MOP_F2_32;
                            end
                        end
                        bshe_pkg::MODE_MUR64:
                        begin
                            if (fill_reg != 3'd0)
                            begin
                                mop_next = bshe_pkg::MOP_TAIL_64;
                            end
                            else
                            begin
                                h_next   = h_reg ^ (h_reg >> 47);
                                mop_next = bshe_pkg::MOP_F2_64;
                            end
                        end
                        default: state_next = bshe_pkg::S_IDLE;
                    endcase
                end
            end

            // hand the digest to the output register and close the message
            bshe_pkg::S_EMIT:
            begin
                if (slot_free)
                begin
                    emit        = 1'b1;
                    h_next      = 64'd0;
                    blk_next    = 64'd0;
                    fill_next   = 3'd0;
                    in_msg_next = 1'b0;
                    state_next  = bshe_pkg::S_IDLE;
                end
            end

            default: state_next = bshe_pkg::S_IDLE;
        endcase
    end

    assign emit_value = res_reg;

    // control and hash state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bshe_pkg::S_IDLE;
            mop_reg    <= bshe_pkg::MOP_INIT64;
            h_reg      <= 64'd0;
            blk_reg    <= 64'd0;
            fill_reg   <= 3'd0;
            in_msg_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mop_reg    <= mop_next;
            h_reg      <= h_next;
            blk_reg    <= blk_next;
            fill_reg   <= fill_next;
            in_msg_reg <= in_msg_next;
        end
    end

    // working registers and captured item fields
    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        res_reg <= res_next;
        if (item_fire && (state_reg == bshe_pkg::S_IDLE))
        begin
            byte_reg    <= data_byte;
            present_reg <= byte_present;
            last_reg    <= last_byte;
            len_reg     <= message_length;
        end
    end

    // an emitted digest always closes the message
    a_emit_closes: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> !in_msg_reg)
        else $error("message still open after digest emit");

    // a product only arrives while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == bshe_pkg::S_MUL_WAIT))
        else $error("multiplier done outside wait state");

    // an accepted transaction always starts with the init step
    a_fire_init: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && !item_stall) |=> (state_reg == bshe_pkg::S_INIT))
        else $error("accepted transaction did not enter init");

    // 32-bit modes leave the upper digest bits clear
    a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (hash_mode == bshe_pkg::MODE_FNV32 || hash_mode == bshe_pkg::MODE_MUR32))
        |-> (emit_value[63:32] == 32'd0))
        else $error("32-bit digest has upper bits set");

endmodule

`default_nettype wire

[rtl/core/byte_stream_hash_engine.sv]
// byte_stream_hash_engine: top level with configuration registers and output register
// depends on bshe_pkg, bshe_mul and bshe_seq
//
// Usage:
//   The item channel (item_valid / item_stall) takes one message byte per
//   transaction with byte_present, last_byte and message_length (read on the
//   first item of a message); an empty message is a single item with
//   byte_present low and last_byte high. The result channel (result_valid /
//   result_stall) carries one 64-bit digest per message, after the last item.
//   cfg_index 0 is hash_mode, 1 is hash_seed; cfg_ready is always high.
// Steps:
//   An item passes the accept, init, byte and finish steps, plus a multiply on
//   the shared 32x32 multiplier where needed: the LL partial product for a
//   32-bit product, the LL, HL and LH ones for a 64-bit one. FNV-1a bytes take
//   one multiply each, Murmur bytes inside a block none. A block boundary adds 3
//   multiplies, the first item of a Murmur64A message one 64-bit multiply,
//   the last Murmur item one plus one more for pending tail bytes.
//   A last item adds an emit step; the digest is valid the cycle after its emit.
// Reset clears the mode, seed and hash state. While result_stall holds a
//   digest, the next digest waits in the sequencer and items stall meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module byte_stream_hash_engine (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_stall,
    input  wire logic [7:0]                     data_byte,
    input  wire logic                           byte_present,
    input  wire logic                           last_byte,
    input  wire logic [31:0]                    message_length,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic [63:0]                         hash_value,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bshe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                    cfg_data
);

    logic [1:0]          mode_reg;
    logic [63:0]         seed_reg;
    logic                result_valid_reg;
    logic [63:0]         result_value_reg;
    logic                item_fire;
    logic                slot_free;
    logic                emit;
    logic [63:0]         emit_value;
    logic                seq_stall;
    bshe_pkg::mul_req_t  mul_req;
    bshe_pkg::mul_rsp_t  mul_rsp;

    assign cfg_ready  = 1'b1;
    assign item_stall = seq_stall;
    assign item_fire  = item_valid && !seq_stall;
    assign slot_free  = !result_valid_reg || !result_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= bshe_pkg::MODE_FNV32;
            seed_reg <= 64'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bshe_pkg::REG_HASH_MODE: mode_reg <= cfg_data[1:0];
                bshe_pkg::REG_HASH_SEED: seed_reg <= cfg_data;
                default: mode_reg <= mode_reg;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_value_reg <= emit_value;
        end
    end

    assign result_valid = result_valid_reg;
    assign hash_value   = result_value_reg;

    // shared multiplier
    bshe_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // sequencer and hash state
    bshe_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_fire      (item_fire),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .last_byte      (last_byte),
        .message_length (message_length),
        .hash_mode      (mode_reg),
        .hash_seed      (seed_reg),
        .slot_free      (slot_free),
        .item_stall     (seq_stall),
        .emit           (emit),
        .emit_value     (emit_value),
        .mul_req        (mul_req),
        .mul_rsp        (mul_rsp)
    );

endmodule

`default_nettype wire
